>>> rtl/bfh_pkg.sv
// Shared types and constants for the best-fit hole allocator.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package bfh_pkg;

	localparam int FIELD_W  = 16; // size fields on the ports
	localparam int ID_W     = 4;  // hole id / index field on the ports
	localparam int S_DATA_W = 24; // size_value, hole_index, padded
	localparam int M_DATA_W = 40; // hole_id, original_size, remaining_size, padded

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_ALLOC = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} bfh_op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOFIT     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOTLOADED = 2'd3
	} bfh_status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_READ,
		S_RESULT
	} bfh_state_t;

	// controller -> datapath
	typedef struct packed {
		logic cap;      // latch the incoming item, restart the scan
		logic scan_rd;  // read the next hole of the scan
		logic rd_issue; // read the hole named by the item
		logic commit;   // write the result and apply the side effect
	} bfh_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_done; // every loaded hole has been read
		logic out_free;  // result register can take a new item
	} bfh_stat_t;

endpackage

`default_nettype wire

>>> rtl/bfh_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bfh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/bfh_datapath.sv
// Datapath: hole table RAM, hole count, best-fit scan registers, result register.
// Depends on bfh_pkg and bfh_ram.
`default_nettype none

module bfh_datapath
	import bfh_pkg::*;
#(
	parameter int MAX_HOLES = 16,
	parameter int SIZE_BITS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire bfh_cmd_t              cmd,
	output bfh_stat_t                  stat,
	input  wire bfh_op_t               in_op,
	input  wire logic [FIELD_W-1:0]    in_size,
	input  wire logic [ID_W-1:0]       in_index,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       out_granted,
	output logic [ID_W-1:0]            out_id,
	output logic [FIELD_W-1:0]         out_orig,
	output logic [FIELD_W-1:0]         out_rem,
	output bfh_status_t                out_status
);

	localparam int SW = (SIZE_BITS < FIELD_W) ? SIZE_BITS : FIELD_W;
	localparam int IW = $clog2(MAX_HOLES);
	localparam int CW = $clog2(MAX_HOLES + 1);
	localparam logic [CW-1:0] MAX_C = CW'(MAX_HOLES);

	bfh_op_t         op_q;
	logic [SW-1:0]   sz_q;
	logic [ID_W-1:0] idx_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   scan_q;
	logic            cmp_v_s1;
	logic [IW-1:0]   scan_id_s1;
	logic            found_q;
	logic [IW-1:0]   best_id_q;
	logic [SW-1:0]   best_orig_q;
	logic [SW-1:0]   best_rem_q;

	logic            ram_we;
	logic [IW-1:0]   ram_waddr;
	logic [2*SW-1:0] ram_wdata;
	logic            ram_re;
	logic [IW-1:0]   ram_raddr;
	logic [2*SW-1:0] ram_rdata;

	logic [SW-1:0]   rd_rem;
	logic [SW-1:0]   rd_orig;
	logic            full;
	logic            fit;
	logic            idx_loaded;
	logic [SW-1:0]   new_rem;
	logic [IW+3:0]   idx_w;
	logic [CW+3:0]   idx_cmp;
	logic [CW+3:0]   cnt_cmp;
	logic [IW+3:0]   best_id_w;
	logic [SW+15:0]  sz_w;
	logic [SW+15:0]  new_rem_w;
	logic [SW+15:0]  best_orig_w;
	logic [SW+15:0]  rd_orig_w;
	logic [SW+15:0]  rd_rem_w;

	logic               res_gr;
	logic [ID_W-1:0]    res_id;
	logic [FIELD_W-1:0] res_orig;
	logic [FIELD_W-1:0] res_rem;
	bfh_status_t        res_st;

	bfh_ram #(
		.WIDTH (2 * SW),
		.DEPTH (MAX_HOLES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		rd_rem      = ram_rdata[SW-1:0];
		rd_orig     = ram_rdata[2*SW-1:SW];
		full        = (count_q >= MAX_C);
		new_rem     = best_rem_q - sz_q;
		idx_w       = {{IW{1'b0}}, idx_q};
		idx_cmp     = {{CW{1'b0}}, idx_q};
		cnt_cmp     = {4'b0, count_q};
		idx_loaded  = (idx_cmp < cnt_cmp);
		best_id_w   = {4'b0, best_id_q};
		sz_w        = {16'b0, sz_q};
		new_rem_w   = {16'b0, new_rem};
		best_orig_w = {16'b0, best_orig_q};
		rd_orig_w   = {16'b0, rd_orig};
		rd_rem_w    = {16'b0, rd_rem};
		// strict less-than keeps the lowest id on ties
		fit = cmp_v_s1 && (rd_rem >= sz_q) && (!found_q || (rd_rem < best_rem_q));

		stat.scan_done = (scan_q >= count_q);
		stat.out_free  = !out_valid || out_ready;

		ram_re    = cmd.scan_rd || cmd.rd_issue;
		ram_raddr = cmd.scan_rd ? scan_q[IW-1:0] : idx_w[IW-1:0];
		ram_we    = 1'b0;
		ram_waddr = best_id_q;
		ram_wdata = {best_orig_q, new_rem};
		if (op_q == OP_LOAD) begin
			ram_waddr = count_q[IW-1:0];
			ram_wdata = {sz_q, sz_q};
		end

		res_gr   = 1'b0;
		res_id   = '0;
		res_orig = '0;
		res_rem  = '0;
		res_st   = ST_OK;
		case (op_q)
			OP_LOAD: begin
				if (full) begin
					res_st = ST_FULL;
				end else begin
					ram_we   = cmd.commit;
					res_id   = cnt_cmp[3:0];
					res_orig = sz_w[15:0];
					res_rem  = sz_w[15:0];
				end
			end
			OP_ALLOC: begin
				if (found_q) begin
					ram_we   = cmd.commit;
					res_gr   = 1'b1;
					res_id   = best_id_w[3:0];
					res_orig = best_orig_w[15:0];
					res_rem  = new_rem_w[15:0];
				end else begin
					res_st = ST_NOFIT;
				end
			end
			OP_READ: begin
				res_id = idx_q;
				if (idx_loaded) begin
					res_orig = rd_orig_w[15:0];
					res_rem  = rd_rem_w[15:0];
				end else begin
					res_st = ST_NOTLOADED;
				end
			end
			default: begin
				// clear: all zero, status ok
			end
		endcase
	end

	// item and best-fit registers
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			op_q  <= in_op;
			sz_q  <= in_size[SW-1:0];
			idx_q <= in_index;
		end
		if (cmd.scan_rd) begin
			scan_id_s1 <= scan_q[IW-1:0];
		end
		if (fit) begin
			best_id_q   <= scan_id_s1;
			best_orig_q <= rd_orig;
			best_rem_q  <= rd_rem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			scan_q   <= '0;
			cmp_v_s1 <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			cmp_v_s1 <= cmd.scan_rd;
			if (cmd.cap) begin
				scan_q  <= '0;
				found_q <= 1'b0;
			end else begin
				if (cmd.scan_rd) begin
					scan_q <= scan_q + 1'b1;
				end
				if (fit) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				if (op_q == OP_LOAD && !full) begin
					count_q <= count_q + 1'b1;
				end else if (op_q == OP_CLEAR) begin
					count_q <= '0;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_granted <= res_gr;
			out_id      <= res_id;
			out_orig    <= res_orig;
			out_rem     <= res_rem;
			out_status  <= res_st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.commit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

endmodule

`default_nettype wire

>>> rtl/bfh_ctrl.sv
// Controller state machine: sequences load, allocate scan, read and clear.
// Depends on bfh_pkg.
`default_nettype none

module bfh_ctrl
	import bfh_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire bfh_op_t   in_op,
	input  wire bfh_stat_t stat,
	output bfh_cmd_t       cmd
);

	bfh_state_t state_q;
	bfh_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.cap = 1'b1;
					case (in_op)
						OP_ALLOC: state_d = S_SCAN;
						OP_READ:  state_d = S_READ;
						default:  state_d = S_RESULT;
					endcase
				end
			end
			S_SCAN: begin
				// last compare lands in the cycle that sees scan_done
				if (stat.scan_done) begin
					state_d = S_RESULT;
				end else begin
					cmd.scan_rd = 1'b1;
				end
			end
			S_READ: begin
				cmd.rd_issue = 1'b1;
				state_d      = S_RESULT;
			end
			S_RESULT: begin
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/best_fit_hole_allocator.sv
// Top level of the best-fit hole allocator: stream ports, controller, datapath.
// Depends on bfh_pkg, bfh_ctrl, bfh_datapath.
`default_nettype none

// Keeps a table of up to MAX_HOLES holes, each with its loaded size and its
// remaining free size. Operation (in s_tuser) selects load, allocate, read
// or clear; one result item comes back for every item taken. Items are
// handled one at a time. Load and clear go from accept straight to the
// result state; read first issues one table read; allocate first scans
// every loaded hole, one per cycle through the table RAM's single read
// port. The result sits in an output register, so the next item is accepted
// while a result still waits. Ties on allocate go to the lowest hole id.
// Sizes use the low min(SIZE_BITS, 16) bits of size_value.
module best_fit_hole_allocator
	import bfh_pkg::*;
#(
	parameter int MAX_HOLES = 16,
	parameter int SIZE_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [S_DATA_W-1:0] s_tdata,  // size_value[15:0], hole_index[19:16]
	input  wire logic [1:0]          s_tuser,  // operation[1:0]
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [M_DATA_W-1:0]      m_tdata,  // hole_id[3:0], original_size[19:4],
	                                           // remaining_size[35:20]
	output logic [2:0]               m_tuser   // granted[0], status[2:1]
);

	bfh_cmd_t           cmd;
	bfh_stat_t          stat;
	bfh_op_t            in_op;
	logic               granted;
	logic [ID_W-1:0]    hole_id;
	logic [FIELD_W-1:0] original_size;
	logic [FIELD_W-1:0] remaining_size;
	bfh_status_t        status;

	assign in_op = bfh_op_t'(s_tuser);

	bfh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_op    (in_op),
		.stat     (stat),
		.cmd      (cmd)
	);

	bfh_datapath #(
		.MAX_HOLES (MAX_HOLES),
		.SIZE_BITS (SIZE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.in_op       (in_op),
		.in_size     (s_tdata[15:0]),
		.in_index    (s_tdata[19:16]),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_granted (granted),
		.out_id      (hole_id),
		.out_orig    (original_size),
		.out_rem     (remaining_size),
		.out_status  (status)
	);

	assign m_tdata = {4'b0, remaining_size, original_size, hole_id};
	assign m_tuser = {status, granted};

endmodule

`default_nettype wire

>>> rtl/bfh_checker.sv
// Port-level checks for the best-fit hole allocator, bound to the top level.
// Depends on bfh_pkg and best_fit_hole_allocator.
`default_nettype none

module bfh_checker
	import bfh_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                s_tvalid,
	input wire logic                s_tready,
	input wire logic                m_tvalid,
	input wire logic                m_tready,
	input wire logic [M_DATA_W-1:0] m_tdata,
	input wire logic [2:0]          m_tuser
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// one item at a time: no accept right after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is at work");

	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tuser[2:1] == ST_OK)
		else $error("grant with failing status");

	// no fit or full table: nothing but the status is set
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[2:1] == ST_NOFIT || m_tuser[2:1] == ST_FULL)
		|-> m_tdata == '0 && !m_tuser[0])
		else $error("failed item carries data");

	a_rem_le_orig: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[35:20] <= m_tdata[19:4])
		else $error("remaining size above original size");

endmodule

bind best_fit_hole_allocator bfh_checker u_bfh_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

>>> bench/tb_best_fit_hole_allocator.sv
// Self-checking testbench for best_fit_hole_allocator: directed and random traffic
// checked against a behavioral model of the hole table kept inside the bench.
// Depends on bfh_pkg and the RTL of best_fit_hole_allocator.
`timescale 1ns / 100ps

module tb_best_fit_hole_allocator;
	import bfh_pkg::*;

	localparam int TABLE_DEPTH = 16;

	typedef struct packed {
		logic        granted;
		logic [3:0]  hole_id;
		logic [15:0] original_size;
		logic [15:0] remaining_size;
		bfh_status_t status;
	} hole_result_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic [1:0]          s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic [2:0]          m_tuser;

	// behavioral copy of the hole table
	logic [15:0] table_orig [TABLE_DEPTH];
	logic [15:0] table_rem  [TABLE_DEPTH];
	logic [4:0]  table_count;

	hole_result_t pending_results [$];
	int error_count;
	int burst_left;
	int gap_limit;
	int stall_pct;
	int hold_len;

	best_fit_hole_allocator DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("tb_best_fit_hole_allocator NOT OK");
		$finish;
	end

	// Applies one accepted item to the table copy and queues its result.
	task automatic apply_to_table(input bfh_op_t op, input logic [15:0] sz,
			input logic [3:0] idx);
		hole_result_t res;
		int best;
		bit found;
		res = '0;
		res.status = ST_OK;
		best = 0;
		found = 0;
		case (op)
			OP_LOAD: begin
				if (table_count >= TABLE_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					table_orig[table_count] = sz;
					table_rem[table_count]  = sz;
					res.hole_id        = table_count[3:0];
					res.original_size  = sz;
					res.remaining_size = sz;
					table_count        = table_count + 5'd1;
				end
			end
			OP_ALLOC: begin
				for (int i = 0; i < table_count; i++) begin
					if (table_rem[i] >= sz && (!found || table_rem[i] < table_rem[best])) begin
						best  = i;
						found = 1;
					end
				end
				if (!found) begin
					res.status = ST_NOFIT;
				end else begin
					table_rem[best]    = table_rem[best] - sz;
					res.granted        = 1'b1;
					res.hole_id        = best[3:0];
					res.original_size  = table_orig[best];
					res.remaining_size = table_rem[best];
				end
			end
			OP_READ: begin
				res.hole_id = idx;
				if (idx < table_count) begin
					res.original_size  = table_orig[idx];
					res.remaining_size = table_rem[idx];
				end else begin
					res.status = ST_NOTLOADED;
				end
			end
			default: begin
				table_count = '0;
			end
		endcase
		pending_results.push_back(res);
	endtask

	task automatic send_item(input bfh_op_t op, input logic [15:0] sz,
			input logic [3:0] idx);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = (gap_limit > 0) ? $urandom_range(gap_limit) : 0;
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, idx, sz};
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		apply_to_table(op, sz, idx);
	endtask

	task automatic wait_for_drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic report_mismatch(input string field, input int expv, input int gotv);
		$display("%0t: %s mismatch: expected %0d, got %0d", $realtime, field, expv, gotv);
		error_count++;
	endtask

	// result checker
	always @(posedge clk) begin
		hole_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected item", 0, 1);
			end else begin
				want = pending_results.pop_front();
				if (m_tuser[0] !== want.granted)
					report_mismatch("granted", want.granted, m_tuser[0]);
				if (m_tdata[3:0] !== want.hole_id)
					report_mismatch("hole_id", want.hole_id, m_tdata[3:0]);
				if (m_tdata[19:4] !== want.original_size)
					report_mismatch("original_size", want.original_size, m_tdata[19:4]);
				if (m_tdata[35:20] !== want.remaining_size)
					report_mismatch("remaining_size", want.remaining_size, m_tdata[35:20]);
				if (m_tuser[2:1] !== want.status)
					report_mismatch("status", want.status, m_tuser[2:1]);
			end
		end
	end

	// receiver: random stalls, or one long hold-off when asked
	initial begin : receiver
		int n;
		m_tready = 1'b1;
		forever begin
			@(negedge clk);
			if (hold_len > 0) begin
				n = hold_len;
				hold_len = 0;
				m_tready <= 1'b0;
				repeat (n) @(negedge clk);
				m_tready <= 1'b1;
			end else if (stall_pct == 0) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic test_empty_table();
		send_item(OP_CLEAR, 16'h0, 4'h0);
		send_item(OP_READ, 16'h0, 4'h0);
		send_item(OP_READ, 16'hFFFF, 4'hF);
		send_item(OP_ALLOC, 16'd5, 4'h0);
	endtask

	task automatic test_best_fit_choice();
		send_item(OP_LOAD, 16'hFFFF, 4'h0);
		send_item(OP_LOAD, 16'h0, 4'h0);
		send_item(OP_LOAD, 16'd100, 4'h0);
		send_item(OP_LOAD, 16'd100, 4'h0);
		send_item(OP_LOAD, 16'd50, 4'h0);
		send_item(OP_ALLOC, 16'd100, 4'h0);   // tie between ids 2 and 3, exact fit
		send_item(OP_ALLOC, 16'd0, 4'h0);     // zero request, tie on empty holes
		send_item(OP_ALLOC, 16'hFFFF, 4'h0);
		send_item(OP_ALLOC, 16'd60, 4'h0);
		send_item(OP_ALLOC, 16'd1000, 4'h0);  // nothing fits
		send_item(OP_READ, 16'h0, 4'h3);
	endtask

	task automatic test_full_table();
		while (table_count < TABLE_DEPTH)
			send_item(OP_LOAD, 16'($urandom), 4'h0);
		send_item(OP_LOAD, 16'h1234, 4'hF);
		send_item(OP_READ, 16'h0, 4'hF);
		send_item(OP_CLEAR, 16'hFFFF, 4'hF);
	endtask

	task automatic test_output_backpressure();
		gap_limit = 0;
		stall_pct = 0;
		hold_len  = 200;
		for (int i = 0; i < 24; i++)
			send_item((i % 3 == 0) ? OP_ALLOC : OP_LOAD, 16'($urandom_range(300)),
				4'($urandom));
		wait_for_drain();
	endtask

	task automatic test_random_traffic(input int n, input int gaps, input int stalls);
		int r;
		int pick;
		logic [15:0] sz;
		logic [3:0] idx;
		gap_limit = gaps;
		stall_pct = stalls;
		for (int k = 0; k < n; k++) begin
			r   = $urandom_range(99);
			idx = 4'($urandom);
			sz  = 16'($urandom);
			pick = (table_count > 0) ? $urandom_range(table_count - 1) : 0;
			if (r < 3) begin
				send_item(OP_CLEAR, sz, idx);
			end else if (r < 35) begin
				case ($urandom_range(3))
					0: ;
					1: sz = 16'($urandom_range(1, 8) * 32);   // ties
					2: sz = 16'($urandom_range(15));
					default: sz = $urandom_range(1) ? 16'hFFFF : 16'h0;
				endcase
				send_item(OP_LOAD, sz, idx);
			end else if (r < 80) begin
				case ($urandom_range(4))
					0: ;
					1: sz = 16'($urandom_range(64));
					2: if (table_count > 0) sz = table_rem[pick];
					3: sz = 16'h0;
					default: sz = (table_count > 0) ? table_rem[pick] + 16'd1 : 16'hFFFF;
				endcase
				send_item(OP_ALLOC, sz, idx);
			end else begin
				if (table_count > 0 && $urandom_range(1))
					idx = 4'(pick);
				send_item(OP_READ, sz, idx);
			end
		end
	endtask

	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = '0;
		table_count = '0;
		error_count = 0;
		burst_left  = 0;
		gap_limit   = 0;
		stall_pct   = 0;
		hold_len    = 0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			table_orig[i] = '0;
			table_rem[i]  = '0;
		end
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		gap_limit = 3;
		stall_pct = 20;
		test_empty_table();
		test_best_fit_choice();
		test_full_table();
		wait_for_drain();
		test_output_backpressure();
		test_random_traffic(600, 0, 0);
		wait_for_drain();
		test_random_traffic(700, 6, 30);
		test_random_traffic(600, 15, 70);

		wait_for_drain();
		repeat (40) @(posedge clk);
		if (error_count == 0)
			$display("tb_best_fit_hole_allocator OK");
		else
			$display("tb_best_fit_hole_allocator NOT OK");
		$finish;
	end

endmodule

>>> best_fit_hole_allocator.f
rtl/bfh_pkg.sv
rtl/bfh_ram.sv
rtl/bfh_datapath.sv
rtl/bfh_ctrl.sv
rtl/best_fit_hole_allocator.sv
rtl/bfh_checker.sv
bench/tb_best_fit_hole_allocator.sv
